@@ sv/sfd_pkg.sv @@
`default_nettype none
package sfd_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int AW   = $clog2(BUFFER_DEPTH);
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);
  localparam int PW   = $clog2(BUFFER_DEPTH + 4);
  localparam int ROWS = (BUFFER_DEPTH + 3) / 4;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [1:0] ACT_FEED  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
    logic [2:0] read_width;
  } in_t;

  typedef struct packed {
    logic        frame_end;
    logic        full_drop;
    logic [31:0] read_value;
    logic        read_error;
    logic [8:0]  message_length;
  } out_t;

  // one decoded transaction handed from front to back
  typedef struct packed {
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [AW-1:0] rd_addr;
    logic [3:0]    rd_mask;
    logic          frame_end;
    logic          full_drop;
    logic          read_error;
    logic [8:0]    msg_len;
  } cmd_t;

endpackage
`default_nettype wire

@@ sv/slip_frame_decoder_with_field_reader.sv @@
// slip frame decoder with little-endian field reader
//
// input channel: in_data (action, byte_in, read_width) is taken at a clock edge
//   with in_push high and in_full low; one transaction may enter every cycle
// result channel: one result per input transaction, in order; the oldest is on
//   out_data while out_empty is low and leaves at an edge with out_pop high
// path: a result passes the front update, the bank read, then the result queue;
//   sustained rate is one transaction per cycle while results are popped
// the front keeps the parser state (count, read pointer, escape and address
//   flags) and turns each transaction into a bank write or a bank read
// the back holds the payload in four byte-wide banks so a 1 to 4 byte field
//   at any offset is read in one access, then rotated and masked
// stall: a held pop fills the four-entry result queue, then the two-entry
//   command queue, and then in_full rises; nothing is lost
// reset: rst_n low at a clock edge empties both queues and clears the parser;
//   the payload store is not cleared and needs no clearing pass
`default_nettype none
module slip_frame_decoder_with_field_reader
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire in_t  in_data,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  cmd_t front_cmd;
  cmd_t back_cmd;
  logic accept;
  logic q_empty;
  logic take;

  // accepted transaction updates parser state right away
  assign accept = in_push && !in_full;

  sfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cmd     (front_cmd)
  );

  // short queue decouples front stalls from back stalls
  sfd_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (take),
    .pop_cmd  (back_cmd),
    .full     (in_full),
    .empty    (q_empty)
  );

  // banked store, read alignment and result queue
  sfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (back_cmd),
    .cmd_take  (take),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

@@ sv/sfd_front.sv @@
`default_nettype none
module sfd_front
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  wire in_t  in_data,
  output cmd_t      cmd
);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic          esc_r, esc_nxt;
  logic          adr_done_r, adr_done_nxt;
  logic [2:0]    w_eff;

  assign w_eff = (in_data.read_width > 3'd4) ? 3'd4 : in_data.read_width;

  always_comb begin
    cnt_nxt      = cnt_r;
    rp_nxt       = rp_r;
    esc_nxt      = esc_r;
    adr_done_nxt = adr_done_r;
    cmd          = '0;
    cmd.wr_addr  = cnt_r[AW-1:0];
    cmd.rd_addr  = rp_r[AW-1:0];
    unique case (in_data.action)
      ACT_FEED: begin
        priority if (cnt_r == CW'(BUFFER_DEPTH)) begin
          cmd.full_drop = 1'b1;
        end else if (in_data.byte_in == SLIP_END) begin
          if (cnt_r != '0) begin
            cmd.frame_end = 1'b1;
            esc_nxt       = 1'b0;
            adr_done_nxt  = 1'b0;
          end
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          if (in_data.byte_in == SLIP_ESC_END) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = SLIP_END;
            cnt_nxt     = cnt_r + 1'b1;
          end else if (in_data.byte_in == SLIP_ESC_ESC) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_data = SLIP_ESC;
            cnt_nxt     = cnt_r + 1'b1;
          end
        end else if (in_data.byte_in == SLIP_ESC) begin
          esc_nxt = 1'b1;
        end else if (!adr_done_r && in_data.byte_in == 8'h00) begin
          // address terminator: stored, pointer moves past it
          adr_done_nxt = 1'b1;
          cmd.wr_en    = 1'b1;
          cmd.wr_data  = 8'h00;
          cnt_nxt      = cnt_r + 1'b1;
          rp_nxt       = PW'(cnt_r) + 1'b1;
        end else begin
          cmd.wr_en   = 1'b1;
          cmd.wr_data = in_data.byte_in;
          cnt_nxt     = cnt_r + 1'b1;
        end
      end
      ACT_READ: begin
        if (rp_r >= PW'(cnt_r)) begin
          cmd.read_error = 1'b1;
        end else begin
          for (int i = 0; i < 4; i++) begin
            cmd.rd_mask[i] = (3'(i) < w_eff) && ((rp_r + PW'(i)) < PW'(cnt_r));
          end
          rp_nxt = rp_r + PW'(w_eff);
        end
      end
      ACT_FLUSH: begin
        cnt_nxt      = '0;
        rp_nxt       = '0;
        esc_nxt      = 1'b0;
        adr_done_nxt = 1'b0;
      end
      default: begin
      end
    endcase
    cmd.msg_len = 9'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rp_r       <= '0;
      esc_r      <= 1'b0;
      adr_done_r <= 1'b0;
    end else if (accept) begin
      cnt_r      <= cnt_nxt;
      rp_r       <= rp_nxt;
      esc_r      <= esc_nxt;
      adr_done_r <= adr_done_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/sfd_cmd_queue.sv @@
`default_nettype none
module sfd_cmd_queue
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      pop_cmd,
  output logic      full,
  output logic      empty
);

  // two-entry queue between front and back
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

@@ sv/sfd_back.sv @@
`default_nettype none
module sfd_back
  import sfd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  wire cmd_t cmd,
  output logic      cmd_take,
  output logic      out_empty,
  input  wire logic out_pop,
  output out_t      out_data
);

  logic [7:0]    rdata_r [4];
  logic          s1_v_r;
  logic [1:0]    s1_lo_r;
  logic [3:0]    s1_mask_r;
  logic          s1_fe_r, s1_fd_r, s1_err_r;
  logic [8:0]    s1_len_r;

  out_t          oq_r [4];
  logic [1:0]    owp_r, orp_r;
  logic [2:0]    ocnt_r;
  out_t          res;
  logic          opop;

  // issue only with room for everything in flight
  assign cmd_take = cmd_valid && ((ocnt_r + {2'b0, s1_v_r}) < 3'd4);

  // four byte banks, one per low address code
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [7:0]    bank_mem [ROWS];
    logic [RW-1:0] rd_row;
    logic [RW-1:0] wr_row;

    assign rd_row = RW'(cmd.rd_addr >> 2) + RW'(2'(k) < cmd.rd_addr[1:0]);
    assign wr_row = RW'(cmd.wr_addr >> 2);

    always_ff @(posedge clk) begin
      if (cmd_take && cmd.wr_en && cmd.wr_addr[1:0] == 2'(k)) begin
        bank_mem[wr_row] <= cmd.wr_data;
      end
      if (cmd_take) begin
        rdata_r[k] <= bank_mem[rd_row];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd_take;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s1_lo_r   <= cmd.rd_addr[1:0];
      s1_mask_r <= cmd.rd_mask;
      s1_fe_r   <= cmd.frame_end;
      s1_fd_r   <= cmd.full_drop;
      s1_err_r  <= cmd.read_error;
      s1_len_r  <= cmd.msg_len;
    end
  end

  always_comb begin
    res                = '0;
    res.frame_end      = s1_fe_r;
    res.full_drop      = s1_fd_r;
    res.read_error     = s1_err_r;
    res.message_length = s1_len_r;
    for (int i = 0; i < 4; i++) begin
      res.read_value[8*i +: 8] = s1_mask_r[i] ? rdata_r[2'(s1_lo_r + 2'(i))] : 8'h00;
    end
  end

  assign out_empty = (ocnt_r == 3'd0);
  assign out_data  = oq_r[orp_r];
  assign opop      = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      oq_r[owp_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      if (s1_v_r) owp_r <= owp_r + 1'b1;
      if (opop)   orp_r <= orp_r + 1'b1;
      ocnt_r <= ocnt_r + {2'b0, s1_v_r} - {2'b0, opop};
    end
  end

endmodule
`default_nettype wire

@@ sv/sfd_checker.sv @@
`default_nettype none
module sfd_checker
  import sfd_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_full,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire out_t out_data
);

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result withdrawn without pop");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.read_error) |-> (out_data.read_value == 32'd0))
    else $error("read error with nonzero value");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_data.frame_end && out_data.full_drop))
    else $error("frame end and full drop together");

endmodule

bind slip_frame_decoder_with_field_reader sfd_checker u_sfd_checker (.*);
`default_nettype wire
